// ===== rtl/wfp_pkg.sv =====
// Shared types and constants for the WebSocket frame parser.
// No dependencies; every file of the block but the two interfaces imports this package.
package wfp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_RESERVED = 3'd2,
    ERR_OPCODE   = 3'd3,
    ERR_CLOSELEN = 3'd4,
    ERR_LENGTH   = 3'd5
  } err_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [7:0] FIN_MASK  = 8'h80;
  localparam logic [7:0] RSV_MASK  = 8'h70;
  localparam logic [7:0] OP_MASK   = 8'h0f;
  localparam logic [7:0] LEN_MASK  = 8'h7f;
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  // Parser state as it stands after the current beat, before any end-of-frame reset.
  typedef struct packed {
    logic        complete;
    logic [2:0]  pending_error;
    logic [7:0]  first_flags;
    logic        has_mask;
    logic [63:0] length;
    logic [63:0] counter;
    logic [31:0] mask_key;
  } parse_view_t;

  typedef struct packed {
    logic        frame_end;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [31:0] mask_key_out;
  } verdict_t;

endpackage

// ===== rtl/wfp_in_if.sv =====
// Input channel of the frame parser: one raw frame byte per beat.
// Stands alone; no package needed.
interface wfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/wfp_out_if.sv =====
// Result channel of the frame parser: one result per input byte.
// Stands alone; no package needed.
interface wfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_is_payload;
  logic        frame_end;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        mask_present;
  logic [63:0] payload_length;
  logic [31:0] mask_key_out;

  modport source (
    output valid, output out_byte, output byte_is_payload, output frame_end,
    output frame_ok, output error_code, output fin_flag, output frame_opcode,
    output mask_present, output payload_length, output mask_key_out, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_is_payload, input frame_end,
    input frame_ok, input error_code, input fin_flag, input frame_opcode,
    input mask_present, input payload_length, input mask_key_out, output ready
  );
endinterface

// ===== rtl/wfp_parser.sv =====
// Header parser and payload unmasker: holds the frame state, one byte per enable.
// Depends on wfp_pkg.
module wfp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic [7:0]          out_byte,
  output logic                byte_is_payload,
  output wfp_pkg::parse_view_t view
);
  import wfp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  hbi, hbi_next;
  logic [7:0]  first_flags, first_flags_next;
  logic [63:0] len_acc, len_acc_next;
  logic [31:0] mask_key, mask_key_next;
  logic        has_mask, has_mask_next;
  logic [63:0] pay_cnt, pay_cnt_next;
  logic [2:0]  pend_err, pend_err_next;
  logic [3:0]  op_in;
  logic [7:0]  key_byte;

  assign op_in = data_byte[3:0] & OP_MASK[3:0];

  always_comb begin
    case (pay_cnt[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next       = phase;
    hbi_next         = hbi;
    first_flags_next = first_flags;
    len_acc_next     = len_acc;
    mask_key_next    = mask_key;
    has_mask_next    = has_mask;
    pay_cnt_next     = pay_cnt;
    pend_err_next    = pend_err;
    out_byte         = 8'd0;
    byte_is_payload  = 1'b0;
    case (phase)
      PH_FIRST: begin
        first_flags_next = data_byte;
        if ((data_byte & RSV_MASK) != 8'd0) begin
          pend_err_next = ERR_RESERVED;
        end else if (op_in != OP_TEXT && op_in != OP_BINARY && op_in != OP_CLOSE) begin
          pend_err_next = ERR_OPCODE;
        end else begin
          pend_err_next = ERR_NONE;
        end
        phase_next = PH_SECOND;
      end
      PH_SECOND: begin
        has_mask_next = data_byte[7];
        len_acc_next  = 64'd0;
        mask_key_next = 32'd0;
        pay_cnt_next  = 64'd0;
        if (data_byte[6:0] == LEN_CODE16) begin
          phase_next = PH_EXTLEN;
          hbi_next   = 4'd2;
        end else if (data_byte[6:0] == LEN_CODE64) begin
          phase_next = PH_EXTLEN;
          hbi_next   = 4'd8;
        end else begin
          len_acc_next = {57'd0, data_byte[6:0] & LEN_MASK[6:0]};
          phase_next   = data_byte[7] ? PH_KEY : PH_PAYLOAD;
          hbi_next     = data_byte[7] ? 4'd4 : 4'd0;
        end
      end
      PH_EXTLEN: begin
        len_acc_next = {len_acc[55:0], data_byte};
        hbi_next     = (hbi != 4'd0) ? hbi - 4'd1 : hbi;
        if (hbi_next == 4'd0) begin
          phase_next = has_mask ? PH_KEY : PH_PAYLOAD;
          hbi_next   = has_mask ? 4'd4 : 4'd0;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], data_byte};
        hbi_next      = (hbi != 4'd0) ? hbi - 4'd1 : hbi;
        if (hbi_next == 4'd0) begin
          phase_next = PH_PAYLOAD;
        end
      end
      default: begin
        if (pay_cnt < len_acc) begin
          out_byte        = has_mask ? (data_byte ^ key_byte) : data_byte;
          byte_is_payload = 1'b1;
        end
        if (pay_cnt != '1) begin
          pay_cnt_next = pay_cnt + 64'd1;
        end
        phase_next = PH_PAYLOAD;
      end
    endcase
  end

  assign view.complete      = (phase_next == PH_PAYLOAD);
  assign view.pending_error = pend_err_next;
  assign view.first_flags   = first_flags_next;
  assign view.has_mask      = has_mask_next;
  assign view.length        = len_acc_next;
  assign view.counter       = pay_cnt_next;
  assign view.mask_key      = mask_key_next;

  // The last byte of a frame returns everything to the reset state.
  always_ff @(posedge clk) begin
    if (rst || (en && last_byte)) begin
      phase       <= PH_FIRST;
      hbi         <= 4'd0;
      first_flags <= 8'd0;
      len_acc     <= 64'd0;
      mask_key    <= 32'd0;
      has_mask    <= 1'b0;
      pay_cnt     <= 64'd0;
      pend_err    <= 3'd0;
    end else if (en) begin
      phase       <= phase_next;
      hbi         <= hbi_next;
      first_flags <= first_flags_next;
      len_acc     <= len_acc_next;
      mask_key    <= mask_key_next;
      has_mask    <= has_mask_next;
      pay_cnt     <= pay_cnt_next;
      pend_err    <= pend_err_next;
    end
  end
endmodule

// ===== rtl/wfp_verdict.sv =====
// End-of-frame checks: picks the first failing check and the reported header fields.
// Depends on wfp_pkg.
module wfp_verdict (
  input  logic                 last_byte,
  input  wfp_pkg::parse_view_t view,
  output wfp_pkg::verdict_t    verdict
);
  import wfp_pkg::*;

  logic [3:0] op;
  err_t       err;

  assign op = view.first_flags[3:0] & OP_MASK[3:0];

  always_comb begin
    if (!view.complete) begin
      err = ERR_SHORT;
    end else if (view.pending_error != ERR_NONE) begin
      err = err_t'(view.pending_error);
    end else if (op == OP_CLOSE && view.length != 64'd2) begin
      err = ERR_CLOSELEN;
    end else if (view.counter != view.length) begin
      err = ERR_LENGTH;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    verdict = '0;
    if (last_byte) begin
      verdict.frame_end  = 1'b1;
      verdict.frame_ok   = (err == ERR_NONE);
      verdict.error_code = err;
      if (view.complete) begin
        verdict.fin_flag       = (view.first_flags & FIN_MASK) != 8'd0;
        verdict.frame_opcode   = op;
        verdict.mask_present   = view.has_mask;
        verdict.payload_length = view.length;
        verdict.mask_key_out   = view.has_mask ? view.mask_key : 32'd0;
      end
    end
  end
endmodule

// ===== rtl/websocket_frame_parser_top.sv =====
// WebSocket frame header parser, one byte per beat in and one result per beat out.
// Path: an accepted input beat is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the result register advances when it is empty or being taken,
// and the input register when it is empty or the result register advances.
// Reset: synchronous rst empties both registers and returns the parser to the first header byte.
module websocket_frame_parser_top (
  input  logic         clk,
  input  logic         rst,
  wfp_in_if.sink       in_ch,
  wfp_out_if.source    out_ch
);
  import wfp_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        advance;

  logic        out_valid;
  logic [7:0]  res_byte;
  logic        res_pay;
  verdict_t    res_verdict;

  logic [7:0]  pb_byte;
  logic        pb_pay;
  parse_view_t view;
  verdict_t    verdict;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte <= in_ch.data_byte;
      s1_last <= in_ch.last_byte;
    end
  end

  wfp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .en              (s1_valid && advance),
    .data_byte       (s1_byte),
    .last_byte       (s1_last),
    .out_byte        (pb_byte),
    .byte_is_payload (pb_pay),
    .view            (view)
  );

  wfp_verdict u_verdict (
    .last_byte (s1_last),
    .view      (view),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_byte    <= pb_byte;
      res_pay     <= pb_pay;
      res_verdict <= verdict;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.out_byte        = res_byte;
  assign out_ch.byte_is_payload = res_pay;
  assign out_ch.frame_end       = res_verdict.frame_end;
  assign out_ch.frame_ok        = res_verdict.frame_ok;
  assign out_ch.error_code      = res_verdict.error_code;
  assign out_ch.fin_flag        = res_verdict.fin_flag;
  assign out_ch.frame_opcode    = res_verdict.frame_opcode;
  assign out_ch.mask_present    = res_verdict.mask_present;
  assign out_ch.payload_length  = res_verdict.payload_length;
  assign out_ch.mask_key_out    = res_verdict.mask_key_out;
endmodule

// ===== rtl/wfp_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
// Depends on wfp_pkg and the ports of websocket_frame_parser_top.
module wfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_is_payload,
  input logic        frame_end,
  input logic        frame_ok,
  input logic [2:0]  error_code,
  input logic [63:0] payload_length,
  input logic [31:0] mask_key_out
);
  import wfp_pkg::*;

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> error_code == ERR_NONE && !frame_ok &&
      payload_length == 64'd0 && mask_key_out == 32'd0)
    else $error("verdict fields set on a byte that does not end the frame");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_ok == (frame_end && error_code == ERR_NONE))
    else $error("frame_ok disagrees with error_code");

  a_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_is_payload |-> out_byte == 8'd0)
    else $error("header or excess byte gave a nonzero output byte");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");
endmodule

bind websocket_frame_parser_top wfp_checker u_wfp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_byte        (out_ch.out_byte),
  .byte_is_payload (out_ch.byte_is_payload),
  .frame_end       (out_ch.frame_end),
  .frame_ok        (out_ch.frame_ok),
  .error_code      (out_ch.error_code),
  .payload_length  (out_ch.payload_length),
  .mask_key_out    (out_ch.mask_key_out)
);

// ===== verif/websocket_frame_parser_top_tb.sv =====
// Self-checking testbench for websocket_frame_parser_top: frames go in byte by byte,
// and every result beat is checked against a built-in parser model in a scoreboard class.
// Depends on wfp_pkg, wfp_in_if, wfp_out_if and the top module of the block.
module websocket_frame_parser_top_tb;
  import wfp_pkg::*;

  localparam int unsigned STIM_BYTES   = 1150;
  localparam int unsigned STALL_LIMIT  = 200;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [3:0]  OP_CTRL_RSVD = 4'hf;

  typedef enum logic [1:0] {
    FORM_7,
    FORM_16,
    FORM_64
  } len_form_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_payload;
    verdict_t   verdict;
  } beat_result_t;

  class frame_checker;
    phase_t      phase;
    logic [3:0]  hdr_left;
    logic [7:0]  flags;
    logic [63:0] len_acc;
    logic [31:0] key;
    logic        has_mask;
    logic [63:0] pay_count;
    err_t        pend;

    beat_result_t pending_results[$];
    int mismatches;
    int failures;

    function new();
      clear_state();
      mismatches = 0;
      failures   = 0;
    endfunction

    function void clear_state();
      phase     = PH_FIRST;
      hdr_left  = '0;
      flags     = '0;
      len_acc   = '0;
      key       = '0;
      has_mask  = 1'b0;
      pay_count = '0;
      pend      = ERR_NONE;
    endfunction

    function void header_done();
      if (has_mask) begin
        phase    = PH_KEY;
        hdr_left = 4'd4;
      end else begin
        phase    = PH_PAYLOAD;
        hdr_left = '0;
      end
    endfunction

    // Advance the parser by one accepted byte and queue the result it causes.
    function void take_byte(logic [7:0] b, logic last);
      beat_result_t r;
      logic [3:0]   op;
      logic [7:0]   k;
      logic         complete;
      err_t         err;
      r = '0;
      case (phase)
        PH_FIRST: begin
          flags = b;
          op = b[3:0] & OP_MASK[3:0];
          if ((b & RSV_MASK) != 0) pend = ERR_RESERVED;
          else if (op != OP_TEXT && op != OP_BINARY && op != OP_CLOSE) pend = ERR_OPCODE;
          else pend = ERR_NONE;
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          has_mask  = b[7];
          len_acc   = '0;
          key       = '0;
          pay_count = '0;
          if ((b[6:0] & LEN_MASK[6:0]) == LEN_CODE16) begin
            phase    = PH_EXTLEN;
            hdr_left = 4'd2;
          end else if ((b[6:0] & LEN_MASK[6:0]) == LEN_CODE64) begin
            phase    = PH_EXTLEN;
            hdr_left = 4'd8;
          end else begin
            len_acc = {57'd0, b[6:0]};
            header_done();
          end
        end
        PH_EXTLEN: begin
          len_acc = {len_acc[55:0], b};
          if (hdr_left != 0) hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) header_done();
        end
        PH_KEY: begin
          key = {key[23:0], b};
          if (hdr_left != 0) hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) phase = PH_PAYLOAD;
        end
        default: begin
          if (pay_count < len_acc) begin
            k = has_mask ? key[8 * (3 - pay_count[1:0]) +: 8] : 8'h00;
            r.out_byte   = b ^ k;
            r.is_payload = 1'b1;
          end
          // The byte counter sticks at all ones instead of wrapping.
          if (pay_count != '1) pay_count = pay_count + 64'd1;
          phase = PH_PAYLOAD;
        end
      endcase

      if (last) begin
        complete = (phase == PH_PAYLOAD);
        op = flags[3:0] & OP_MASK[3:0];
        if (!complete) err = ERR_SHORT;
        else if (pend != ERR_NONE) err = pend;
        else if (op == OP_CLOSE && len_acc != 64'd2) err = ERR_CLOSELEN;
        else if (pay_count != len_acc) err = ERR_LENGTH;
        else err = ERR_NONE;
        r.verdict.frame_end  = 1'b1;
        r.verdict.frame_ok   = (err == ERR_NONE);
        r.verdict.error_code = err;
        if (complete) begin
          r.verdict.fin_flag       = |(flags & FIN_MASK);
          r.verdict.frame_opcode   = op;
          r.verdict.mask_present   = has_mask;
          r.verdict.payload_length = len_acc;
          r.verdict.mask_key_out   = has_mask ? key : 32'h0;
        end
        clear_state();
      end
      pending_results.push_back(r);
    endfunction

    function int field_differs(string name, logic [63:0] e, logic [63:0] a);
      if (e === a) return 0;
      if (mismatches < REPORT_MAX)
        $display("mismatch on %s: expected %0h, got %0h", name, e, a);
      mismatches++;
      return 1;
    endfunction

    function void compare_result(beat_result_t act);
      beat_result_t e;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("result beat with nothing expected: %0h", act);
        mismatches++;
        failures++;
        return;
      end
      e = pending_results.pop_front();
      failures += field_differs("out_byte", 64'(e.out_byte), 64'(act.out_byte));
      failures += field_differs("byte_is_payload", 64'(e.is_payload), 64'(act.is_payload));
      failures += field_differs("frame_end", 64'(e.verdict.frame_end),
                                64'(act.verdict.frame_end));
      failures += field_differs("frame_ok", 64'(e.verdict.frame_ok),
                                64'(act.verdict.frame_ok));
      failures += field_differs("error_code", 64'(e.verdict.error_code),
                                64'(act.verdict.error_code));
      failures += field_differs("fin_flag", 64'(e.verdict.fin_flag),
                                64'(act.verdict.fin_flag));
      failures += field_differs("frame_opcode", 64'(e.verdict.frame_opcode),
                                64'(act.verdict.frame_opcode));
      failures += field_differs("mask_present", 64'(e.verdict.mask_present),
                                64'(act.verdict.mask_present));
      failures += field_differs("payload_length", e.verdict.payload_length,
                                act.verdict.payload_length);
      failures += field_differs("mask_key_out", 64'(e.verdict.mask_key_out),
                                64'(act.verdict.mask_key_out));
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  wfp_in_if  in_ch();
  wfp_out_if out_ch();

  websocket_frame_parser_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_checker sb = new();
  logic [7:0]   frame_bytes[$];
  int unsigned  bytes_sent;
  int unsigned  idle_cycles;
  bit           steady;

  // Both sides stop idling while this is set, so back-to-back beats occur.
  function void pick_idling();
    steady = ($urandom_range(0, 5) == 0);
  endfunction

  function void push_header(logic fin, logic [2:0] rsv, logic [3:0] op, logic masked,
                            logic [63:0] len, len_form_t form, logic [31:0] mkey);
    frame_bytes.push_back({fin, rsv, op});
    case (form)
      FORM_16: begin
        frame_bytes.push_back({masked, LEN_CODE16});
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
      end
      FORM_64: begin
        frame_bytes.push_back({masked, LEN_CODE64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8 * i +: 8]);
      end
      default: frame_bytes.push_back({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(mkey[8 * i +: 8]);
    end
  endfunction

  function void push_random_bytes(int unsigned n);
    for (int unsigned i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
    pick_idling();
  endtask

  task automatic directed_frames();
    push_header(1'b1, 3'd0, OP_TEXT, 1'b0, 64'd0, FORM_7, 32'h0);
    send_frame();
    push_header(1'b1, 3'd0, OP_BINARY, 1'b1, 64'd2, FORM_7, 32'hffff_ffff);
    frame_bytes.push_back(8'hff);
    frame_bytes.push_back(8'h00);
    send_frame();
    push_header(1'b0, 3'd0, OP_CLOSE, 1'b1, 64'd2, FORM_7, 32'h0);
    push_random_bytes(2);
    send_frame();
    // Close frame whose length is not two.
    push_header(1'b1, 3'd0, OP_CLOSE, 1'b0, 64'd1, FORM_7, 32'h0);
    push_random_bytes(1);
    send_frame();
    push_header(1'b1, 3'd7, OP_TEXT, 1'b0, 64'd0, FORM_7, 32'h0);
    send_frame();
    push_header(1'b1, 3'd0, OP_CTRL_RSVD, 1'b0, 64'd0, FORM_7, 32'h0);
    send_frame();
    // Header cut short after its first byte.
    frame_bytes.push_back({1'b1, 3'd0, OP_TEXT});
    send_frame();
    // Non-minimal 16-bit length.
    push_header(1'b1, 3'd0, OP_TEXT, 1'b0, 64'd1, FORM_16, 32'h0);
    frame_bytes.push_back(8'hff);
    send_frame();
    // 64-bit length with its top bit set, no payload behind it.
    push_header(1'b1, 3'd0, OP_BINARY, 1'b0, 64'h8000_0000_0000_0001, FORM_64, 32'h0);
    send_frame();
    // Bytes past the declared payload.
    push_header(1'b1, 3'd0, OP_TEXT, 1'b0, 64'd1, FORM_7, 32'h0);
    push_random_bytes(3);
    send_frame();
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned hdr_count;
    int unsigned cut;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  op;
    logic        masked;
    logic [31:0] mkey;
    logic [63:0] len;
    len_form_t   form;
    kind   = $urandom_range(0, 99);
    fin    = 1'($urandom_range(0, 1));
    masked = 1'($urandom_range(0, 1));
    mkey   = $urandom;
    rsv    = 3'd0;
    case ($urandom_range(0, 2))
      0: op = OP_TEXT;
      1: op = OP_BINARY;
      default: op = OP_CLOSE;
    endcase
    if (op == OP_CLOSE)
      len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 5)) : 64'd2;
    else
      len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 140)) :
                                          64'($urandom_range(0, 12));
    if (len > 125) form = ($urandom_range(0, 1) == 0) ? FORM_16 : FORM_64;
    else begin
      case ($urandom_range(0, 4))
        0: form = FORM_16;
        1: form = FORM_64;
        default: form = FORM_7;
      endcase
    end
    if (kind < 8) rsv = 3'($urandom_range(1, 7));
    else if (kind < 16) begin
      do op = 4'($urandom_range(0, 15));
      while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
    end

    if (kind >= 38 && kind < 41) begin
      // Plain noise.
      push_random_bytes($urandom_range(1, 10));
    end else if (kind >= 41 && kind < 44) begin
      // Huge declared length with only a few bytes behind it.
      form = ($urandom_range(0, 1) == 0) ? FORM_16 : FORM_64;
      len  = (form == FORM_16) ? 64'($urandom_range(200, 65535)) : {$urandom, $urandom};
      push_header(fin, rsv, op, masked, len, form, mkey);
      push_random_bytes($urandom_range(0, 6));
    end else begin
      push_header(fin, rsv, op, masked, len, form, mkey);
      hdr_count = frame_bytes.size();
      push_random_bytes(32'(len));
      if (kind >= 16 && kind < 24) begin
        push_random_bytes($urandom_range(1, 4));
      end else if (kind >= 24 && kind < 32) begin
        if (len == 0) push_random_bytes($urandom_range(1, 4));
        else begin
          cut = $urandom_range(1, 32'(len));
          frame_bytes = frame_bytes[0 : frame_bytes.size() - 1 - cut];
        end
      end else if (kind >= 32 && kind < 38) begin
        cut = $urandom_range(1, hdr_count - 1);
        frame_bytes = frame_bytes[0 : cut - 1];
      end
    end
    send_frame();
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    bytes_sent      = 0;
    pick_idling();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_frames();
    while (bytes_sent < STIM_BYTES) random_frame();
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("websocket_frame_parser_top_tb OK");
    end else begin
      $display("websocket_frame_parser_top_tb NOT OK");
    end
    $finish;
  end

  // Result side: random stalls on ready, each accepted beat goes to the scoreboard.
  initial begin
    int unsigned  stall;
    beat_result_t act;
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      act.out_byte               = out_ch.out_byte;
      act.is_payload             = out_ch.byte_is_payload;
      act.verdict.frame_end      = out_ch.frame_end;
      act.verdict.frame_ok       = out_ch.frame_ok;
      act.verdict.error_code     = out_ch.error_code;
      act.verdict.fin_flag       = out_ch.fin_flag;
      act.verdict.frame_opcode   = out_ch.frame_opcode;
      act.verdict.mask_present   = out_ch.mask_present;
      act.verdict.payload_length = out_ch.payload_length;
      act.verdict.mask_key_out   = out_ch.mask_key_out;
      sb.compare_result(act);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("websocket_frame_parser_top_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
